/* sv/dcrs_pkg.sv */
// ----------------------------------------------------------------------------
// dcrs_pkg: shared types and constants for the day cycle RGB scheduler
// Clock geometry, codes for functions, keys, channels and frame phases, and
// the segment lookup used by the time keeper.
// ----------------------------------------------------------------------------
package dcrs_pkg;

  localparam int HOURS_PER_DAY      = 24;
  localparam int SEGMENTS_EACH_HOUR = 2;
  localparam int SEG_LEN            = 60 / SEGMENTS_EACH_HOUR;
  localparam int SEGS_PER_DAY       = HOURS_PER_DAY * SEGMENTS_EACH_HOUR;
  localparam int SEG_W              = (SEGS_PER_DAY > 1) ? $clog2(SEGS_PER_DAY) : 1;
  localparam int NUM_CH             = 3;

  localparam int MINUTES_MAX = 59;
  localparam int HALF_HOUR   = 30;

  localparam int RECIP_SHIFT = 24;
  localparam int RECIP       = ((1 << RECIP_SHIFT) + SEG_LEN - 1) / SEG_LEN;
  localparam int SAT_LIMIT   = 256 * SEG_LEN;

  localparam logic [2:0] STEP_FINE   = 3'd1;
  localparam logic [2:0] STEP_COARSE = 3'd5;

  localparam logic [1:0] CH_RED   = 2'd0;
  localparam logic [1:0] CH_GREEN = 2'd1;
  localparam logic [1:0] CH_BLUE  = 2'd2;

  localparam logic [7:0] BYTE_SYNC      = 8'hFF;
  localparam logic [7:0] BYTE_ZERO      = 8'h00;
  localparam logic [7:0] LEVEL_MAX      = 8'hFF;
  localparam logic [7:0] LEVEL_SENT_MAX = 8'hFE;

  typedef enum logic [1:0] {
    FUNC_TICK = 2'd0,
    FUNC_KEY  = 2'd1,
    FUNC_LOAD = 2'd2,
    FUNC_IDLE = 2'd3
  } func_t;

  typedef enum logic [3:0] {
    KEY_BLU_DN   = 4'd0,
    KEY_MIN_ZERO = 4'd1,
    KEY_FWD      = 4'd2,
    KEY_BACK     = 4'd3,
    KEY_STEP     = 4'd4,
    KEY_RED_UP   = 4'd5,
    KEY_RED_DN   = 4'd6,
    KEY_GRN_UP   = 4'd7,
    KEY_GRN_DN   = 4'd8,
    KEY_BLU_UP   = 4'd9
  } key_t;

  typedef enum logic [2:0] {
    PH_REPORT = 3'd0,
    PH_SYNC   = 3'd1,
    PH_ZERO   = 3'd2,
    PH_RED    = 3'd3,
    PH_GREEN  = 3'd4,
    PH_BLUE   = 3'd5
  } phase_t;

  typedef struct packed {
    logic [SEG_W-1:0] seg;
    logic [SEG_W-1:0] nseg;
    logic [5:0]       m;
    logic [4:0]       hour;
    logic [5:0]       minute;
  } clock_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [4:0] hour;
    logic [5:0] minute;
  } report_t;

  function automatic logic [2:0] seg_of_hour(input logic [5:0] minute);
    logic [2:0] r;
    r = 3'd0;
    for (int j = 1; j < SEGMENTS_EACH_HOUR; j++) begin
      if (32'(minute) >= j * SEG_LEN) begin
        r = 3'(j);
      end
    end
    return r;
  endfunction

endpackage

/* sv/dcrs_tbl.sv */
// ----------------------------------------------------------------------------
// dcrs_tbl: one schedule table of a colour channel
// One write port, two registered read ports with write bypass; entries never
// written read as zero through per-entry valid bits.
// ----------------------------------------------------------------------------
module dcrs_tbl import dcrs_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             we,
  input  logic [SEG_W-1:0] waddr,
  input  logic [7:0]       wdata,
  input  logic             re,
  input  logic [SEG_W-1:0] raddr_a,
  input  logic [SEG_W-1:0] raddr_b,
  output logic [7:0]       rdata_a,
  output logic [7:0]       rdata_b
);

  logic [7:0]              mem_r [SEGS_PER_DAY];
  logic [SEGS_PER_DAY-1:0] vld_r;
  logic [7:0]              da_r;
  logic [7:0]              db_r;
  logic                    va_r;
  logic                    vb_r;
  logic                    hit_a;
  logic                    hit_b;

  assign hit_a = we && (waddr == raddr_a);
  assign hit_b = we && (waddr == raddr_b);

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      da_r <= hit_a ? wdata : mem_r[raddr_a];
      db_r <= hit_b ? wdata : mem_r[raddr_b];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
      va_r  <= 1'b0;
      vb_r  <= 1'b0;
    end else begin
      if (we) begin
        vld_r[waddr] <= 1'b1;
      end
      if (re) begin
        va_r <= hit_a || vld_r[raddr_a];
        vb_r <= hit_b || vld_r[raddr_b];
      end
    end
  end

  assign rdata_a = va_r ? da_r : '0;
  assign rdata_b = vb_r ? db_r : '0;

endmodule

/* sv/dcrs_time.sv */
// ----------------------------------------------------------------------------
// dcrs_time: time-of-day keeper
// Holds minute, hour and minute step; works out the time after the word on
// offer and the segment, next segment and minute within segment for it.
// ----------------------------------------------------------------------------
module dcrs_time import dcrs_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       fire,
  input  logic [1:0] func,
  input  logic [3:0] key,
  input  logic       paused,
  output clock_t     clk_nxt
);

  logic [5:0]       minute_r;
  logic [5:0]       minute_nxt;
  logic [4:0]       hour_r;
  logic [4:0]       hour_nxt;
  logic [2:0]       step_r;
  logic [2:0]       step_nxt;
  logic [6:0]       sum;
  logic [4:0]       hour_inc;
  logic [4:0]       hour_dec;
  logic [2:0]       sih;
  logic [SEG_W-1:0] seg;

  assign sum      = 7'(minute_r) + 7'(step_r);
  assign hour_inc = (hour_r == 5'(HOURS_PER_DAY - 1)) ? 5'd0 : hour_r + 5'd1;
  assign hour_dec = (hour_r == 5'd0) ? 5'(HOURS_PER_DAY - 1) : hour_r - 5'd1;

  always_comb begin
    minute_nxt = minute_r;
    hour_nxt   = hour_r;
    step_nxt   = step_r;
    case (func)
      FUNC_TICK: begin
        if (!paused) begin
          if (sum > 7'(MINUTES_MAX)) begin
            minute_nxt = 6'd0;
            hour_nxt   = hour_inc;
          end else begin
            minute_nxt = sum[5:0];
          end
        end
      end
      FUNC_KEY: begin
        case (key)
          KEY_MIN_ZERO: minute_nxt = 6'd0;
          KEY_FWD: begin
            if (minute_r < 6'(HALF_HOUR)) begin
              minute_nxt = minute_r + 6'(HALF_HOUR);
            end else begin
              minute_nxt = minute_r - 6'(HALF_HOUR);
              hour_nxt   = hour_inc;
            end
          end
          KEY_BACK: begin
            if (minute_r >= 6'(HALF_HOUR)) begin
              minute_nxt = minute_r - 6'(HALF_HOUR);
            end else begin
              minute_nxt = minute_r + 6'(HALF_HOUR);
              hour_nxt   = hour_dec;
            end
          end
          KEY_STEP: step_nxt = (step_r == STEP_FINE) ? STEP_COARSE : STEP_FINE;
          default: ;
        endcase
      end
      default: ;
    endcase
  end

  assign sih = seg_of_hour(minute_nxt);
  assign seg = SEG_W'(32'(hour_nxt) * SEGMENTS_EACH_HOUR) + SEG_W'(sih);

  always_comb begin
    clk_nxt.seg    = seg;
    clk_nxt.nseg   = (seg == SEG_W'(SEGS_PER_DAY - 1)) ? '0 : seg + SEG_W'(1);
    clk_nxt.m      = minute_nxt - 6'(32'(sih) * SEG_LEN);
    clk_nxt.hour   = hour_nxt;
    clk_nxt.minute = minute_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      minute_r <= 6'd0;
      hour_r   <= 5'd0;
      step_r   <= STEP_FINE;
    end else if (fire) begin
      minute_r <= minute_nxt;
      hour_r   <= hour_nxt;
      step_r   <= step_nxt;
    end
  end

endmodule

/* sv/dcrs_lerp.sv */
// ----------------------------------------------------------------------------
// dcrs_lerp: interpolation of one colour channel
// Forms the weighted sum of the two point values into a register, then
// divides by the segment length through a reciprocal and saturates.
// ----------------------------------------------------------------------------
module dcrs_lerp import dcrs_pkg::*; (
  input  logic       clk,
  input  logic       en,
  input  logic [7:0] base_a,
  input  logic [7:0] trim_a,
  input  logic [7:0] base_b,
  input  logic [7:0] trim_b,
  input  logic [5:0] m,
  output logic [7:0] level
);

  logic signed [9:0]  a;
  logic signed [9:0]  b;
  logic signed [6:0]  wa;
  logic signed [6:0]  wb;
  logic signed [17:0] pa;
  logic signed [17:0] pb;
  logic signed [17:0] n_nxt;
  logic signed [17:0] n_r;
  logic [13:0]        nlo;
  logic [37:0]        prod;

  assign a     = $signed({2'b00, base_a}) + $signed({{2{trim_a[7]}}, trim_a});
  assign b     = $signed({2'b00, base_b}) + $signed({{2{trim_b[7]}}, trim_b});
  assign wb    = $signed({1'b0, m});
  assign wa    = $signed(7'(SEG_LEN) - {1'b0, m});
  assign pa    = 18'(a) * 18'(wa);
  assign pb    = 18'(b) * 18'(wb);
  assign n_nxt = pa + pb;

  always_ff @(posedge clk) begin
    if (en) begin
      n_r <= n_nxt;
    end
  end

  assign nlo  = n_r[13:0];
  assign prod = 38'(nlo) * 38'(RECIP);

  always_comb begin
    if (n_r < 0) begin
      level = 8'd0;
    end else if (n_r >= 18'(SAT_LIMIT)) begin
      level = LEVEL_MAX;
    end else begin
      level = prod[RECIP_SHIFT +: 8];
    end
  end

endmodule

/* sv/dcrs_frame.sv */
// ----------------------------------------------------------------------------
// dcrs_frame: result register and serial frame sequencer
// Holds one tick's report, then sends FF 00 r g b when the colour differs
// from the last one sent.
// ----------------------------------------------------------------------------
module dcrs_frame import dcrs_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       load,
  input  report_t    rep,
  input  logic       out_stall,
  output logic       adv,
  output logic       out_valid,
  output logic       out_kind,
  output logic [7:0] out_byte_value,
  output logic [7:0] out_red,
  output logic [7:0] out_green,
  output logic [7:0] out_blue,
  output logic [4:0] out_hour_now,
  output logic [5:0] out_minute_now,
  output logic       out_last
);

  phase_t     phase_r;
  phase_t     phase_nxt;
  logic       busy_r;
  logic       busy_nxt;
  logic       chg_r;
  report_t    rep_r;
  logic [7:0] sent_red_r;
  logic [7:0] sent_green_r;
  logic [7:0] sent_blue_r;
  logic       diff;
  logic       out_fire;

  assign diff     = (rep.red != sent_red_r) || (rep.green != sent_green_r) ||
                    (rep.blue != sent_blue_r);
  assign out_fire = busy_r && !out_stall;
  assign adv      = !busy_r || (!out_stall && out_last);

  always_comb begin
    phase_nxt = phase_r;
    busy_nxt  = busy_r;
    if (out_fire) begin
      if (out_last) begin
        busy_nxt = 1'b0;
      end else begin
        case (phase_r)
          PH_REPORT: phase_nxt = PH_SYNC;
          PH_SYNC:   phase_nxt = PH_ZERO;
          PH_ZERO:   phase_nxt = PH_RED;
          PH_RED:    phase_nxt = PH_GREEN;
          PH_GREEN:  phase_nxt = PH_BLUE;
          default:   phase_nxt = PH_REPORT;
        endcase
      end
    end
    if (load) begin
      busy_nxt  = 1'b1;
      phase_nxt = PH_REPORT;
    end
  end

  always_comb begin
    out_valid      = busy_r;
    out_kind       = 1'b1;
    out_byte_value = 8'd0;
    out_red        = 8'd0;
    out_green      = 8'd0;
    out_blue       = 8'd0;
    out_hour_now   = 5'd0;
    out_minute_now = 6'd0;
    out_last       = 1'b0;
    case (phase_r)
      PH_REPORT: begin
        out_kind       = 1'b0;
        out_red        = rep_r.red;
        out_green      = rep_r.green;
        out_blue       = rep_r.blue;
        out_hour_now   = rep_r.hour;
        out_minute_now = rep_r.minute;
        out_last       = !chg_r;
      end
      PH_SYNC:  out_byte_value = BYTE_SYNC;
      PH_ZERO:  out_byte_value = BYTE_ZERO;
      PH_RED:   out_byte_value = sent_red_r;
      PH_GREEN: out_byte_value = sent_green_r;
      PH_BLUE: begin
        out_byte_value = sent_blue_r;
        out_last       = 1'b1;
      end
      default: out_last = 1'b1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (load) begin
      rep_r <= rep;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_REPORT;
      busy_r       <= 1'b0;
      chg_r        <= 1'b0;
      sent_red_r   <= 8'd0;
      sent_green_r <= 8'd0;
      sent_blue_r  <= 8'd0;
    end else begin
      phase_r <= phase_nxt;
      busy_r  <= busy_nxt;
      if (load) begin
        chg_r <= diff;
        if (diff) begin
          sent_red_r   <= (rep.red == LEVEL_MAX) ? LEVEL_SENT_MAX : rep.red;
          sent_green_r <= (rep.green == LEVEL_MAX) ? LEVEL_SENT_MAX : rep.green;
          sent_blue_r  <= (rep.blue == LEVEL_MAX) ? LEVEL_SENT_MAX : rep.blue;
        end
      end
    end
  end

endmodule

/* sv/day_cycle_rgb_scheduler.sv */
// ----------------------------------------------------------------------------
// day_cycle_rgb_scheduler: time-of-day RGB colour scheduler
// Clock, schedule tables, per-channel interpolation and serial frame output.
// ----------------------------------------------------------------------------
// A word is taken every cycle while the result register is free or is giving
// up its last result. A tick passes the s1 and s2 stage registers into the
// result register, then holds the result port for one word (report only) or
// six words (report plus the FF 00 r g b frame); keys and table loads give no
// result. The pipeline holds while a frame is still being sent. Tables read
// as zero after reset with no clearing pass; the paused register may be
// written at any time the block is idle.
// ----------------------------------------------------------------------------
module day_cycle_rgb_scheduler import dcrs_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_we,
  input  logic       cfg_wdata,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] in_func,
  input  logic [3:0] in_key_code,
  input  logic [5:0] in_entry_index,
  input  logic [1:0] in_channel,
  input  logic [7:0] in_entry_value,
  output logic       out_valid,
  input  logic       out_stall,
  output logic       out_kind,
  output logic [7:0] out_byte_value,
  output logic [7:0] out_red,
  output logic [7:0] out_green,
  output logic [7:0] out_blue,
  output logic [4:0] out_hour_now,
  output logic [5:0] out_minute_now,
  output logic       out_last
);

  logic             paused_r;
  logic             adv;
  logic             in_fire;
  clock_t           clk_nxt;
  logic             idx_ok;

  logic             trim_hit;
  logic [1:0]       trim_ch;
  logic             trim_up;

  logic             s1_tick_r;
  logic             s1_trim_r;
  logic [1:0]       s1_ch_r;
  logic             s1_up_r;
  logic [SEG_W-1:0] s1_seg_r;
  logic [4:0]       s1_hour_r;
  logic [5:0]       s1_min_r;
  logic [5:0]       s1_m_r;

  logic             s2_tick_r;
  logic [4:0]       s2_hour_r;
  logic [5:0]       s2_min_r;

  logic             base_we [NUM_CH];
  logic             trim_we [NUM_CH];
  logic [7:0]       trim_wdata [NUM_CH];
  logic [7:0]       base_a [NUM_CH];
  logic [7:0]       base_b [NUM_CH];
  logic [7:0]       trim_a [NUM_CH];
  logic [7:0]       trim_b [NUM_CH];
  logic [7:0]       level [NUM_CH];
  report_t          rep;

  assign in_stall = !adv;
  assign in_fire  = in_valid && adv;
  assign idx_ok   = 32'(in_entry_index) < SEGS_PER_DAY;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      paused_r <= 1'b0;
    end else if (cfg_we) begin
      paused_r <= cfg_wdata;
    end
  end

  dcrs_time u_time (
    .clk     (clk),
    .rst_n   (rst_n),
    .fire    (in_fire),
    .func    (in_func),
    .key     (in_key_code),
    .paused  (paused_r),
    .clk_nxt (clk_nxt)
  );

  always_comb begin
    trim_hit = 1'b0;
    trim_ch  = CH_RED;
    trim_up  = 1'b0;
    case (in_key_code)
      KEY_RED_UP: begin trim_hit = 1'b1; trim_ch = CH_RED;   trim_up = 1'b1; end
      KEY_RED_DN: begin trim_hit = 1'b1; trim_ch = CH_RED;                   end
      KEY_GRN_UP: begin trim_hit = 1'b1; trim_ch = CH_GREEN; trim_up = 1'b1; end
      KEY_GRN_DN: begin trim_hit = 1'b1; trim_ch = CH_GREEN;                 end
      KEY_BLU_UP: begin trim_hit = 1'b1; trim_ch = CH_BLUE;  trim_up = 1'b1; end
      KEY_BLU_DN: begin trim_hit = 1'b1; trim_ch = CH_BLUE;                  end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_tick_r <= 1'b0;
      s1_trim_r <= 1'b0;
      s2_tick_r <= 1'b0;
    end else if (adv) begin
      s1_tick_r <= in_fire && (in_func == FUNC_TICK);
      s1_trim_r <= in_fire && (in_func == FUNC_KEY) && trim_hit;
      s2_tick_r <= s1_tick_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_ch_r   <= trim_ch;
      s1_up_r   <= trim_up;
      s1_seg_r  <= clk_nxt.seg;
      s1_hour_r <= clk_nxt.hour;
      s1_min_r  <= clk_nxt.minute;
      s1_m_r    <= clk_nxt.m;
      s2_hour_r <= s1_hour_r;
      s2_min_r  <= s1_min_r;
    end
  end

  for (genvar c = 0; c < NUM_CH; c++) begin : g_ch
    assign base_we[c]    = in_fire && (in_func == FUNC_LOAD) && idx_ok &&
                           (in_channel == 2'(c));
    assign trim_we[c]    = adv && s1_trim_r && (s1_ch_r == 2'(c));
    assign trim_wdata[c] = s1_up_r ? trim_a[c] + 8'd1 : trim_a[c] - 8'd1;

    dcrs_tbl u_base (
      .clk     (clk),
      .rst_n   (rst_n),
      .we      (base_we[c]),
      .waddr   (SEG_W'(in_entry_index)),
      .wdata   (in_entry_value),
      .re      (adv),
      .raddr_a (clk_nxt.seg),
      .raddr_b (clk_nxt.nseg),
      .rdata_a (base_a[c]),
      .rdata_b (base_b[c])
    );

    dcrs_tbl u_trim (
      .clk     (clk),
      .rst_n   (rst_n),
      .we      (trim_we[c]),
      .waddr   (s1_seg_r),
      .wdata   (trim_wdata[c]),
      .re      (adv),
      .raddr_a (clk_nxt.seg),
      .raddr_b (clk_nxt.nseg),
      .rdata_a (trim_a[c]),
      .rdata_b (trim_b[c])
    );

    dcrs_lerp u_lerp (
      .clk    (clk),
      .en     (adv),
      .base_a (base_a[c]),
      .trim_a (trim_a[c]),
      .base_b (base_b[c]),
      .trim_b (trim_b[c]),
      .m      (s1_m_r),
      .level  (level[c])
    );
  end

  always_comb begin
    rep.red    = level[0];
    rep.green  = level[1];
    rep.blue   = level[2];
    rep.hour   = s2_hour_r;
    rep.minute = s2_min_r;
  end

  dcrs_frame u_frame (
    .clk            (clk),
    .rst_n          (rst_n),
    .load           (adv && s2_tick_r),
    .rep            (rep),
    .out_stall      (out_stall),
    .adv            (adv),
    .out_valid      (out_valid),
    .out_kind       (out_kind),
    .out_byte_value (out_byte_value),
    .out_red        (out_red),
    .out_green      (out_green),
    .out_blue       (out_blue),
    .out_hour_now   (out_hour_now),
    .out_minute_now (out_minute_now),
    .out_last       (out_last)
  );

endmodule

/* verif/day_cycle_rgb_scheduler_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// day_cycle_rgb_scheduler_checker: result predictor and comparator
// Watches the input, result and register ports of the scheduler, keeps its
// own copy of the clock, the schedule and trim tables and the last colour
// sent, and compares every result word, field by field, with the oldest
// predicted word.
// ----------------------------------------------------------------------------
module day_cycle_rgb_scheduler_checker import dcrs_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_we,
  input  logic       cfg_wdata,
  input  logic       in_valid,
  input  logic       in_stall,
  input  logic [1:0] in_func,
  input  logic [3:0] in_key_code,
  input  logic [5:0] in_entry_index,
  input  logic [1:0] in_channel,
  input  logic [7:0] in_entry_value,
  input  logic       out_valid,
  input  logic       out_stall,
  input  logic       out_kind,
  input  logic [7:0] out_byte_value,
  input  logic [7:0] out_red,
  input  logic [7:0] out_green,
  input  logic [7:0] out_blue,
  input  logic [4:0] out_hour_now,
  input  logic [5:0] out_minute_now,
  input  logic       out_last,
  output int         fails,
  output int         pending
);

  typedef struct packed {
    logic       kind;
    logic [7:0] byte_value;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [4:0] hour;
    logic [5:0] minute;
    logic       last;
  } sched_word_t;

  sched_word_t       due_words[$];
  logic              paused_q;
  int                cur_minute;
  int                cur_hour;
  int                cur_step;
  logic [7:0]        base_lvl [NUM_CH][SEGS_PER_DAY];
  logic signed [7:0] trim_lvl [NUM_CH][SEGS_PER_DAY];
  logic [7:0]        sent_red;
  logic [7:0]        sent_green;
  logic [7:0]        sent_blue;

  function automatic int current_seg();
    return cur_hour * SEGMENTS_EACH_HOUR + cur_minute / SEG_LEN;
  endfunction

  function automatic logic [7:0] blend_level(int ch, int seg, int nseg, int m);
    int a;
    int b;
    int n;
    a = int'(base_lvl[ch][seg]) + int'(trim_lvl[ch][seg]);
    b = int'(base_lvl[ch][nseg]) + int'(trim_lvl[ch][nseg]);
    n = a * (SEG_LEN - m) + b * m;
    if (n <= 0) return 8'd0;
    if (n / SEG_LEN > 255) return 8'd255;
    return 8'(n / SEG_LEN);
  endfunction

  function automatic logic [7:0] sent_level(logic [7:0] lvl);
    return (lvl == LEVEL_MAX) ? LEVEL_SENT_MAX : lvl;
  endfunction

  task automatic schedule_tick();
    int          seg;
    int          nseg;
    int          m;
    logic [7:0]  r;
    logic [7:0]  g;
    logic [7:0]  b;
    logic        changed;
    logic [7:0]  frame [5];
    sched_word_t w;
    if (!paused_q) cur_minute += cur_step;
    if (cur_minute > MINUTES_MAX) begin
      cur_minute = 0;
      cur_hour++;
    end
    if (cur_hour >= HOURS_PER_DAY) cur_hour = 0;
    seg  = current_seg();
    m    = cur_minute % SEG_LEN;
    nseg = (seg + 1 >= SEGS_PER_DAY) ? 0 : seg + 1;
    r = blend_level(CH_RED, seg, nseg, m);
    g = blend_level(CH_GREEN, seg, nseg, m);
    b = blend_level(CH_BLUE, seg, nseg, m);
    changed = (r != sent_red) || (g != sent_green) || (b != sent_blue);
    w = '0;
    w.red    = r;
    w.green  = g;
    w.blue   = b;
    w.hour   = 5'(cur_hour);
    w.minute = 6'(cur_minute);
    w.last   = !changed;
    due_words.push_back(w);
    if (changed) begin
      sent_red   = sent_level(r);
      sent_green = sent_level(g);
      sent_blue  = sent_level(b);
      frame = '{BYTE_SYNC, BYTE_ZERO, sent_red, sent_green, sent_blue};
      for (int i = 0; i < 5; i++) begin
        w = '0;
        w.kind       = 1'b1;
        w.byte_value = frame[i];
        w.last       = (i == 4);
        due_words.push_back(w);
      end
    end
  endtask

  task automatic apply_key(logic [3:0] code);
    int seg;
    seg = current_seg();
    case (code)
      KEY_MIN_ZERO: cur_minute = 0;
      KEY_FWD: begin
        if (cur_minute < HALF_HOUR) begin
          cur_minute += HALF_HOUR;
        end else begin
          cur_minute -= HALF_HOUR;
          cur_hour = (cur_hour + 1) % HOURS_PER_DAY;
        end
      end
      KEY_BACK: begin
        if (cur_minute >= HALF_HOUR) begin
          cur_minute -= HALF_HOUR;
        end else begin
          cur_minute += HALF_HOUR;
          cur_hour = (cur_hour == 0) ? HOURS_PER_DAY - 1 : cur_hour - 1;
        end
      end
      KEY_STEP:   cur_step = (cur_step == STEP_FINE) ? STEP_COARSE : STEP_FINE;
      KEY_RED_UP: trim_lvl[CH_RED][seg] += 8'sd1;
      KEY_RED_DN: trim_lvl[CH_RED][seg] -= 8'sd1;
      KEY_GRN_UP: trim_lvl[CH_GREEN][seg] += 8'sd1;
      KEY_GRN_DN: trim_lvl[CH_GREEN][seg] -= 8'sd1;
      KEY_BLU_UP: trim_lvl[CH_BLUE][seg] += 8'sd1;
      KEY_BLU_DN: trim_lvl[CH_BLUE][seg] -= 8'sd1;
      default: ;
    endcase
  endtask

  task automatic check_field(string what, int want, int got);
    if (want != got) begin
      $display("%0t: %s mismatch: expected %0d (0x%0h), got %0d (0x%0h)",
               $time, what, want, want, got, got);
      fails++;
    end
  endtask

  always @(posedge clk) begin
    sched_word_t w;
    if (!rst_n) begin
      due_words.delete();
      paused_q   = 1'b0;
      cur_minute = 0;
      cur_hour   = 0;
      cur_step   = STEP_FINE;
      base_lvl   = '{default: '0};
      trim_lvl   = '{default: '0};
      sent_red   = '0;
      sent_green = '0;
      sent_blue  = '0;
    end else begin
      if (out_valid && !out_stall) begin
        if (due_words.size() == 0) begin
          $display("%0t: unexpected result word: expected none, got kind %0d byte 0x%0h",
                   $time, out_kind, out_byte_value);
          fails++;
        end else begin
          w = due_words.pop_front();
          check_field("kind", w.kind, out_kind);
          check_field("byte_value", w.byte_value, out_byte_value);
          check_field("red", w.red, out_red);
          check_field("green", w.green, out_green);
          check_field("blue", w.blue, out_blue);
          check_field("hour_now", w.hour, out_hour_now);
          check_field("minute_now", w.minute, out_minute_now);
          check_field("last", w.last, out_last);
        end
      end
      if (cfg_we) paused_q = cfg_wdata;
      if (in_valid && !in_stall) begin
        case (in_func)
          FUNC_TICK: schedule_tick();
          FUNC_KEY:  apply_key(in_key_code);
          FUNC_LOAD: begin
            if (in_entry_index < SEGS_PER_DAY && in_channel < NUM_CH)
              base_lvl[in_channel][in_entry_index] = in_entry_value;
          end
          default: ;
        endcase
      end
    end
    pending = due_words.size();
  end

endmodule

/* verif/day_cycle_rgb_scheduler_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// day_cycle_rgb_scheduler_test: testbench top for the RGB day scheduler
// Drives table loads, keys and ticks, first a directed set around the clock
// roll-overs, saturation and trim wrap, then random sequences under several
// idle and stall mixes, and gives the verdict from the checker's count.
// ----------------------------------------------------------------------------
module day_cycle_rgb_scheduler_test;
  import dcrs_pkg::*;

  localparam int         STALL_LIMIT   = 4000;
  localparam int         SETTLE_CYCLES = 8;
  localparam int         ITEMS_EACH    = 72;
  localparam logic [3:0] KEY_UNUSED    = 4'd15;
  localparam logic [1:0] CH_NONE       = 2'd3;

  logic       clk;
  logic       rst_n;
  logic       cfg_we;
  logic       cfg_wdata;
  logic       in_valid;
  logic       in_stall;
  logic [1:0] in_func;
  logic [3:0] in_key_code;
  logic [5:0] in_entry_index;
  logic [1:0] in_channel;
  logic [7:0] in_entry_value;
  logic       out_valid;
  logic       out_stall;
  logic       out_kind;
  logic [7:0] out_byte_value;
  logic [7:0] out_red;
  logic [7:0] out_green;
  logic [7:0] out_blue;
  logic [4:0] out_hour_now;
  logic [5:0] out_minute_now;
  logic       out_last;

  int chk_fails;
  int chk_pending;
  int idle_pct;
  int stall_pct;
  int hold_len;
  int quiet_cycles;

  day_cycle_rgb_scheduler dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_func        (in_func),
    .in_key_code    (in_key_code),
    .in_entry_index (in_entry_index),
    .in_channel     (in_channel),
    .in_entry_value (in_entry_value),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_kind       (out_kind),
    .out_byte_value (out_byte_value),
    .out_red        (out_red),
    .out_green      (out_green),
    .out_blue       (out_blue),
    .out_hour_now   (out_hour_now),
    .out_minute_now (out_minute_now),
    .out_last       (out_last)
  );

  day_cycle_rgb_scheduler_checker u_chk (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_func        (in_func),
    .in_key_code    (in_key_code),
    .in_entry_index (in_entry_index),
    .in_channel     (in_channel),
    .in_entry_value (in_entry_value),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_kind       (out_kind),
    .out_byte_value (out_byte_value),
    .out_red        (out_red),
    .out_green      (out_green),
    .out_blue       (out_blue),
    .out_hour_now   (out_hour_now),
    .out_minute_now (out_minute_now),
    .out_last       (out_last),
    .fails          (chk_fails),
    .pending        (chk_pending)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_len > 0) begin
        out_stall <= 1'b1;
        repeat (hold_len) @(negedge clk);
        hold_len = 0;
      end else begin
        out_stall <= ($urandom_range(99) < stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
          $display("day_cycle_rgb_scheduler_test: FAIL");
          $finish;
        end
      end
    end
  end

  // enter and leave at a falling edge; valid stays high on exit
  task automatic push_word(logic [1:0] f, logic [3:0] k, logic [5:0] idx,
                           logic [1:0] ch, logic [7:0] v);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid       <= 1'b1;
    in_func        <= f;
    in_key_code    <= k;
    in_entry_index <= idx;
    in_channel     <= ch;
    in_entry_value <= v;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  task automatic send_tick();
    push_word(FUNC_TICK, 4'($urandom_range(15)), 6'($urandom_range(63)),
              2'($urandom_range(3)), 8'($urandom_range(255)));
  endtask

  task automatic send_key(logic [3:0] k);
    push_word(FUNC_KEY, k, 6'($urandom_range(63)), 2'($urandom_range(3)),
              8'($urandom_range(255)));
  endtask

  task automatic send_load(logic [5:0] idx, logic [1:0] ch, logic [7:0] v);
    push_word(FUNC_LOAD, 4'($urandom_range(15)), idx, ch, v);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (chk_pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_paused(logic v);
    drain();
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [7:0] pick_level();
    case ($urandom_range(3))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  initial begin
    int sel;
    int seg;
    int count;
    rst_n          = 1'b0;
    cfg_we         = 1'b0;
    cfg_wdata      = 1'b0;
    in_valid       = 1'b0;
    in_func        = FUNC_IDLE;
    in_key_code    = '0;
    in_entry_index = '0;
    in_channel     = '0;
    in_entry_value = '0;
    idle_pct       = 0;
    stall_pct      = 0;
    hold_len       = 0;
    quiet_cycles   = 0;
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    write_paused(1'b0);

    // saturation high and low, ignored loads, steady full red
    send_load(6'd0, CH_RED, 8'hFF);
    send_load(6'd1, CH_RED, 8'hFF);
    send_load(6'(SEGS_PER_DAY - 1), CH_BLUE, 8'hFF);
    send_load(6'(SEGS_PER_DAY), CH_RED, 8'hAA);
    send_load(6'h3F, CH_NONE, 8'h55);
    send_key(KEY_RED_UP);
    send_key(KEY_BLU_DN);
    send_tick();
    send_tick();
    send_key(KEY_UNUSED);
    push_word(FUNC_IDLE, 4'hF, 6'h3F, 2'h3, 8'hFF);
    // borrow below midnight, coarse step over the day wrap
    send_key(KEY_BACK);
    send_key(KEY_STEP);
    repeat (6) send_tick();
    send_key(KEY_FWD);
    send_tick();
    send_key(KEY_FWD);
    send_key(KEY_MIN_ZERO);
    send_key(KEY_GRN_UP);
    send_key(KEY_GRN_DN);
    send_key(KEY_RED_DN);
    send_key(KEY_BLU_UP);
    send_key(KEY_STEP);
    send_tick();
    write_paused(1'b1);
    send_tick();
    write_paused(1'b0);

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 62; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 62; end
        default: begin idle_pct = 12; stall_pct = 12; end
      endcase
      if (phase == 1) write_paused(1'b1);
      if (phase == 2) write_paused(1'b0);
      if (phase == 3) write_paused(1'($urandom_range(1)));
      if (phase == 0) begin
        // walk a trim past its signed limit
        repeat (129) send_key(KEY_RED_UP);
        send_tick();
      end
      if (phase == 2) hold_len = 300;
      count = 0;
      while (count < ITEMS_EACH) begin
        sel = $urandom_range(99);
        if (sel < 40) begin
          send_tick();
          count++;
        end else if (sel < 55) begin
          send_key(4'($urandom_range(15)));
          count++;
        end else if (sel < 65) begin
          send_key(4'($urandom_range(9)));
          send_tick();
          count += 2;
        end else if (sel < 75) begin
          seg = $urandom_range(SEGS_PER_DAY - 2);
          for (int ch = 0; ch < NUM_CH; ch++) begin
            send_load(6'(seg), 2'(ch), pick_level());
            send_load(6'(seg + 1), 2'(ch), pick_level());
          end
          send_tick();
          count += 7;
        end else if (sel < 93) begin
          send_load(6'($urandom_range(SEGS_PER_DAY - 1)), 2'($urandom_range(NUM_CH - 1)),
                    pick_level());
          count++;
        end else if (sel < 97) begin
          send_load(6'($urandom_range(63)), 2'($urandom_range(3)), 8'($urandom_range(255)));
          count++;
        end else begin
          push_word(FUNC_IDLE, 4'($urandom_range(15)), 6'($urandom_range(63)),
                    2'($urandom_range(3)), 8'($urandom_range(255)));
        end
      end
    end

    drain();
    repeat (20) @(negedge clk);
    if (chk_fails == 0 && chk_pending == 0) begin
      $display("day_cycle_rgb_scheduler_test: PASS");
    end else begin
      $display("day_cycle_rgb_scheduler_test: FAIL");
    end
    $finish;
  end

endmodule
